// ===== sv/hkd_pkg.sv =====
package hkd_pkg;

	// field widths
	localparam int unsigned CH_W      = 8;
	localparam int unsigned HUE_W     = 9;
	localparam int unsigned CFG_IDX_W = 2;
	// scaled hue is below 360*255, the range products below 2^17
	localparam int unsigned SCALED_W  = 17;
	localparam int unsigned PROD_W    = HUE_W + CH_W;
	// signed working width for the sector sums
	localparam int unsigned SUM_W     = SCALED_W + 1;

	// sector offsets in degrees
	localparam logic signed [SUM_W-1:0] DEG_60  = SUM_W'(60);
	localparam logic signed [SUM_W-1:0] DEG_120 = SUM_W'(120);
	localparam logic signed [SUM_W-1:0] DEG_240 = SUM_W'(240);
	localparam logic signed [SUM_W-1:0] DEG_360 = SUM_W'(360);

	// register reset values
	localparam logic [HUE_W-1:0] HUE_LOW_RST  = HUE_W'(0);
	localparam logic [HUE_W-1:0] HUE_HIGH_RST = HUE_W'(360);

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HUE_LOW  = 2'd0,
		REG_HUE_HIGH = 2'd1
	} reg_idx_t;

	typedef struct packed {
		logic [CH_W-1:0] red_in;
		logic [CH_W-1:0] green_in;
		logic [CH_W-1:0] blue_in;
		logic            frame_end_in;
	} pixel_t;

	typedef struct packed {
		logic [CH_W-1:0] red_out;
		logic [CH_W-1:0] green_out;
		logic [CH_W-1:0] blue_out;
		logic            frame_end_out;
	} result_t;

	// hue analysis handed from the first stage to the key stage
	typedef struct packed {
		logic [CH_W-1:0]     mx;
		logic [CH_W-1:0]     chroma;
		logic [SCALED_W-1:0] scaled;
	} hue_info_t;

endpackage

// ===== sv/hkd_analyze.sv =====
module hkd_analyze (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pixel_valid,
	output logic                pixel_ready,
	input  hkd_pkg::pixel_t     pixel,
	output logic                valid_s1,
	input  logic                ready_s1,
	output hkd_pkg::pixel_t     pixel_s1,
	output hkd_pkg::hue_info_t  info_s1
);

	logic [hkd_pkg::CH_W-1:0] r, g, b, mx, mn;
	logic signed [hkd_pkg::CH_W:0] d_gb, d_br, d_rg;
	logic signed [hkd_pkg::SUM_W-1:0] c_w, sum;
	hkd_pkg::hue_info_t info;

	assign r = pixel.red_in;
	assign g = pixel.green_in;
	assign b = pixel.blue_in;

	// brightest and darkest channel
	always_comb begin
		mx = (r > g) ? r : g;
		if (b > mx) mx = b;
		mn = (r < g) ? r : g;
		if (b < mn) mn = b;
	end

	assign d_gb = $signed({1'b0, g}) - $signed({1'b0, b});
	assign d_br = $signed({1'b0, b}) - $signed({1'b0, r});
	assign d_rg = $signed({1'b0, r}) - $signed({1'b0, g});
	assign c_w  = $signed(hkd_pkg::SUM_W'(mx - mn));

	// hue times chroma per sector, red wins ties, then green
	always_comb begin
		if (r == mx) begin
			sum = hkd_pkg::DEG_60 * hkd_pkg::SUM_W'(d_gb);
			if (sum < 0) sum = sum + hkd_pkg::DEG_360 * c_w;
		end else if (g == mx) begin
			sum = hkd_pkg::DEG_120 * c_w + hkd_pkg::DEG_60 * hkd_pkg::SUM_W'(d_br);
		end else begin
			sum = hkd_pkg::DEG_240 * c_w + hkd_pkg::DEG_60 * hkd_pkg::SUM_W'(d_rg);
		end
	end

	always_comb begin
		info.mx     = mx;
		info.chroma = mx - mn;
		info.scaled = sum[hkd_pkg::SCALED_W-1:0];
	end

	assign pixel_ready = !valid_s1 || ready_s1;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixel_ready) begin
			valid_s1 <= pixel_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (pixel_ready && pixel_valid) begin
			pixel_s1 <= pixel;
			info_s1  <= info;
		end
	end

endmodule

// ===== sv/hkd_key.sv =====
module hkd_key (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [hkd_pkg::HUE_W-1:0] hue_low,
	input  logic [hkd_pkg::HUE_W-1:0] hue_high,
	input  logic                      valid_s1,
	output logic                      ready_s1,
	input  hkd_pkg::pixel_t           pixel_s1,
	input  hkd_pkg::hue_info_t        info_s1,
	output logic                      valid_s2,
	input  logic                      ready_s2,
	output hkd_pkg::result_t          result_s2
);

	logic [hkd_pkg::PROD_W-1:0] low_c, high_c;
	logic                       keep;
	hkd_pkg::result_t           res;

	// range bounds scaled by chroma
	assign low_c  = hkd_pkg::PROD_W'(hue_low)  * hkd_pkg::PROD_W'(info_s1.chroma);
	assign high_c = hkd_pkg::PROD_W'(hue_high) * hkd_pkg::PROD_W'(info_s1.chroma);

	// gray pixels and in-range hues keep their color
	assign keep = (info_s1.chroma == '0) ||
	              ((hkd_pkg::PROD_W'(info_s1.scaled) >= low_c) &&
	               (hkd_pkg::PROD_W'(info_s1.scaled) <= high_c));

	always_comb begin
		res.red_out       = keep ? pixel_s1.red_in   : info_s1.mx;
		res.green_out     = keep ? pixel_s1.green_in : info_s1.mx;
		res.blue_out      = keep ? pixel_s1.blue_in  : info_s1.mx;
		res.frame_end_out = pixel_s1.frame_end_in;
	end

	assign ready_s1 = !valid_s2 || ready_s2;

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (ready_s1 && valid_s1) begin
			result_s2 <= res;
		end
	end

endmodule

// ===== sv/hue_key_desaturate_unit.sv =====
// Hue-keyed desaturation: each pixel's HSV hue is tested exactly against
// [hue_low, hue_high] degrees by cross-multiplying with chroma, so no divider
// is involved. Pixels in range, and gray or black pixels, pass unchanged;
// all others become gray at their brightest channel. frame_end is copied.
// The block takes one pixel beat per clock while the result side is ready. It
// registers the max/min and sector sum, then the outcome of the two range
// multiplies and compares. Back-pressure on the result side
// stalls both stages. Write hue_low (index 0) and hue_high (index 1) only
// while no pixels are in flight; other indexes are ignored.
module hue_key_desaturate_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [hkd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hkd_pkg::HUE_W-1:0]     cfg_data,
	input  logic                          pixel_valid,
	output logic                          pixel_ready,
	input  hkd_pkg::pixel_t               pixel,
	output logic                          result_valid,
	input  logic                          result_ready,
	output hkd_pkg::result_t              result
);

	logic [hkd_pkg::HUE_W-1:0] hue_low_q, hue_high_q;
	logic                      valid_s1, ready_s1;
	hkd_pkg::pixel_t           pixel_s1;
	hkd_pkg::hue_info_t        info_s1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_low_q  <= hkd_pkg::HUE_LOW_RST;
			hue_high_q <= hkd_pkg::HUE_HIGH_RST;
		end else if (cfg_we) begin
			if (cfg_index == hkd_pkg::REG_HUE_LOW)  hue_low_q  <= cfg_data;
			if (cfg_index == hkd_pkg::REG_HUE_HIGH) hue_high_q <= cfg_data;
		end
	end

	hkd_analyze u_analyze (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel       (pixel),
		.valid_s1    (valid_s1),
		.ready_s1    (ready_s1),
		.pixel_s1    (pixel_s1),
		.info_s1     (info_s1)
	);

	hkd_key u_key (
		.clk       (clk),
		.arst_n    (arst_n),
		.hue_low   (hue_low_q),
		.hue_high  (hue_high_q),
		.valid_s1  (valid_s1),
		.ready_s1  (ready_s1),
		.pixel_s1  (pixel_s1),
		.info_s1   (info_s1),
		.valid_s2  (result_valid),
		.ready_s2  (result_ready),
		.result_s2 (result)
	);

endmodule

// ===== tb/sv/hue_key_checker.sv =====
module hue_key_checker
	import hkd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [HUE_W-1:0]     cfg_data,
	input  logic                 pixel_valid,
	input  logic                 pixel_ready,
	input  pixel_t               pixel,
	input  logic                 result_valid,
	input  logic                 result_ready,
	input  result_t              result,
	output int                   fail_count,
	output int                   pending,
	output int                   pixel_count,
	output int                   gray_count
);
	timeunit 1ns;
	timeprecision 1ps;

	// shadow copy of the hue window registers
	logic [HUE_W-1:0] key_low  = HUE_LOW_RST;
	logic [HUE_W-1:0] key_high = HUE_HIGH_RST;

	result_t expected_pixels[$];

	initial begin
		fail_count  = 0;
		pending     = 0;
		pixel_count = 0;
		gray_count  = 0;
	end

	// exact hue window test, scaled by chroma so nothing is divided
	function automatic result_t keyed_pixel(input pixel_t px, input logic [HUE_W-1:0] lo,
			input logic [HUE_W-1:0] hi);
		int r, g, b, mx, mn, c, scaled;
		result_t res;
		r = px.red_in;
		g = px.green_in;
		b = px.blue_in;
		mx = (r > g) ? r : g;
		mx = (mx > b) ? mx : b;
		mn = (r < g) ? r : g;
		mn = (mn < b) ? mn : b;
		c = mx - mn;
		res.red_out       = px.red_in;
		res.green_out     = px.green_in;
		res.blue_out      = px.blue_in;
		res.frame_end_out = px.frame_end_in;
		// gray and black pixels have no hue and pass as they are
		if (c != 0) begin
			// ties on the maximum go to red first, then green
			if (r == mx) begin
				scaled = 60 * (g - b);
				if (scaled < 0)
					scaled += 360 * c;
			end else if (g == mx) begin
				scaled = 120 * c + 60 * (b - r);
			end else begin
				scaled = 240 * c + 60 * (r - g);
			end
			if (scaled < int'(lo) * c || scaled > int'(hi) * c) begin
				res.red_out   = CH_W'(mx);
				res.green_out = CH_W'(mx);
				res.blue_out  = CH_W'(mx);
			end
		end
		return res;
	endfunction

	// watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			key_low  = HUE_LOW_RST;
			key_high = HUE_HIGH_RST;
		end else begin
			// result beat against the oldest expectation
			if (result_valid && result_ready) begin
				if (expected_pixels.size() == 0) begin
					$error("result beat with no pixel outstanding: %h", result);
					fail_count++;
				end else begin
					want = expected_pixels.pop_front();
					if (result.red_out !== want.red_out) begin
						$error("red_out: expected %0d, got %0d", want.red_out, result.red_out);
						fail_count++;
					end
					if (result.green_out !== want.green_out) begin
						$error("green_out: expected %0d, got %0d", want.green_out,
							result.green_out);
						fail_count++;
					end
					if (result.blue_out !== want.blue_out) begin
						$error("blue_out: expected %0d, got %0d", want.blue_out,
							result.blue_out);
						fail_count++;
					end
					if (result.frame_end_out !== want.frame_end_out) begin
						$error("frame_end_out: expected %0d, got %0d", want.frame_end_out,
							result.frame_end_out);
						fail_count++;
					end
				end
			end
			// pixel beat queues its prediction
			if (pixel_valid && pixel_ready) begin
				want = keyed_pixel(pixel, key_low, key_high);
				expected_pixels.push_back(want);
				pixel_count++;
				if ({want.red_out, want.green_out, want.blue_out}
						!= {pixel.red_in, pixel.green_in, pixel.blue_in})
					gray_count++;
			end
			// register writes, other indexes are dropped
			if (cfg_we) begin
				if (cfg_index == REG_HUE_LOW)
					key_low = cfg_data;
				else if (cfg_index == REG_HUE_HIGH)
					key_high = cfg_data;
			end
		end
		pending = expected_pixels.size();
	end

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import hkd_pkg::*;

	localparam int PHASES       = 10;
	localparam int FIXED_PHASES = 7;
	localparam int PHASE_PIXELS = 160;
	localparam int HOLD_CYCLES  = 60;
	localparam int DRAIN_CYCLES = 4;
	localparam int SWATCHES     = 12;

	// indexes past the last register, writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_B = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_HUE_LOW;
	logic [HUE_W-1:0]     cfg_data = '0;
	logic                 pixel_valid = 1'b0;
	logic                 pixel_ready;
	pixel_t               pixel = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	result_t              result;

	int fail_count, pending, pixel_count, gray_count;

	// pacing controls shared by the sender and the receiver
	bit no_idle  = 1'b0;
	bit hold_req = 1'b0;

	hue_key_desaturate_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	hue_key_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.fail_count   (fail_count),
		.pending      (pending),
		.pixel_count  (pixel_count),
		.gray_count   (gray_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit
	initial begin
		#400_000;
		$display("** hue_key_desaturate_unit: FAILED **");
		$finish;
	end

	// result side: random stall per beat, one long hold-off on request
	initial begin : receiver
		int stall;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			stall = no_idle ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
			@(negedge clk);
		end
	end

	// offer one pixel beat, called and returning at a falling edge
	task automatic send_pixel(input pixel_t px);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pixel_valid <= 1'b1;
		pixel       <= px;
		do @(posedge clk); while (!pixel_ready);
		@(negedge clk);
	endtask

	// let every pixel in flight come out before touching registers
	task automatic drain();
		pixel_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// spare index first, then both window registers
	task automatic program_window(input logic [CFG_IDX_W-1:0] spare,
			input logic [HUE_W-1:0] lo, input logic [HUE_W-1:0] hi);
		cfg_we    <= 1'b1;
		cfg_index <= spare;
		cfg_data  <= HUE_W'($urandom);
		@(negedge clk);
		cfg_index <= REG_HUE_LOW;
		cfg_data  <= lo;
		@(negedge clk);
		cfg_index <= REG_HUE_HIGH;
		cfg_data  <= hi;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [CH_W-1:0] clamp_ch(input int v);
		return (v < 0) ? '0 : (v > 255) ? CH_W'(255) : CH_W'(v);
	endfunction

	// mix of plain random, near gray, tied maxima, extremes and pure gray
	function automatic pixel_t random_pixel();
		pixel_t px;
		int kind, base, top, low, pick;
		int edge_vals[4] = '{0, 1, 254, 255};
		kind = $urandom_range(0, 9);
		px.red_in   = CH_W'($urandom);
		px.green_in = CH_W'($urandom);
		px.blue_in  = CH_W'($urandom);
		case (kind)
			5: begin
				base = $urandom_range(0, 255);
				px.red_in   = clamp_ch(base + $urandom_range(0, 6) - 3);
				px.green_in = clamp_ch(base + $urandom_range(0, 6) - 3);
				px.blue_in  = clamp_ch(base + $urandom_range(0, 6) - 3);
			end
			6: begin
				top  = $urandom_range(1, 255);
				low  = $urandom_range(0, top - 1);
				pick = $urandom_range(0, 2);
				px.red_in   = CH_W'((pick == 2) ? low : top);
				px.green_in = CH_W'((pick == 1) ? low : top);
				px.blue_in  = CH_W'((pick == 0) ? low : top);
			end
			7: begin
				px.red_in   = CH_W'(edge_vals[$urandom_range(0, 3)]);
				px.green_in = CH_W'(edge_vals[$urandom_range(0, 3)]);
				px.blue_in  = CH_W'(edge_vals[$urandom_range(0, 3)]);
			end
			8: begin
				px.green_in = px.red_in;
				px.blue_in  = px.red_in;
			end
			default: ;
		endcase
		px.frame_end_in = ($urandom_range(0, 7) == 0);
		return px;
	endfunction

	initial begin : stimulus
		logic [23:0] swatch [SWATCHES] = '{
			24'h000000, 24'hFFFFFF, 24'h808080, 24'hFF0000,
			24'h00FF00, 24'h0000FF, 24'hFFFF00, 24'h00FFFF,
			24'hFF00FF, 24'hFF0001, 24'h010000, 24'hFFFEFE
		};
		int fixed_low  [FIXED_PHASES] = '{0, 0, 360, 511, 300, 45, 0};
		int fixed_high [FIXED_PHASES] = '{360, 0, 360, 511, 100, 200, 511};
		logic [HUE_W-1:0] lo, hi;
		pixel_t px;

		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// swatches under the reset window, then under 120..240 degrees
		for (int pass = 0; pass < 2; pass++) begin
			if (pass == 1) begin
				drain();
				program_window(IDX_SPARE_A, HUE_W'(120), HUE_W'(240));
			end
			for (int i = 0; i < SWATCHES; i++) begin
				px.red_in       = swatch[i][23:16];
				px.green_in     = swatch[i][15:8];
				px.blue_in      = swatch[i][7:0];
				px.frame_end_in = (pass == 0) ? (i == SWATCHES - 1) : i[0];
				send_pixel(px);
			end
		end

		// random pixels over a run of hue windows
		for (int p = 0; p < PHASES; p++) begin
			drain();
			if (p < FIXED_PHASES) begin
				lo = HUE_W'(fixed_low[p]);
				hi = HUE_W'(fixed_high[p]);
			end else begin
				lo = HUE_W'($urandom_range(0, 360));
				hi = ($urandom_range(0, 3) == 0) ? HUE_W'($urandom_range(0, 511))
					: HUE_W'($urandom_range(lo, 360));
			end
			program_window(p[0] ? IDX_SPARE_B : IDX_SPARE_A, lo, hi);
			no_idle = (p == 2 || p == 3 || p == 6);
			// back the result side up long enough to stall pixel input
			if (p == 3)
				hold_req = 1'b1;
			for (int i = 0; i < PHASE_PIXELS; i++)
				send_pixel(random_pixel());
		end

		drain();
		repeat (10) @(negedge clk);
		$display("ran %0d pixels through %0d hue windows plus the reset one",
			pixel_count, PHASES + 1);
		$display("%0d pixels turned gray, the rest kept their channels", gray_count);
		if (fail_count == 0)
			$display("** hue_key_desaturate_unit: PASSED **");
		else
			$display("** hue_key_desaturate_unit: FAILED **");
		$finish;
	end

endmodule
